/* sv/ntd_pkg.sv */
// package: symbol codes, character constants and the symbol decode function for the nibble decoder
package ntd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 13;
  localparam int unsigned NUM_CANDS       = 6;
  localparam int unsigned CAND_IDX_W      = $clog2(NUM_CANDS);

  typedef logic [CAND_IDX_W-1:0] cand_idx_t;

  // symbol codes
  localparam logic [3:0] CODE_PERIOD  = 4'b1010;
  localparam logic [3:0] CODE_SPACE   = 4'b1011;
  localparam logic [3:0] CODE_TAB     = 4'b1100;
  localparam logic [3:0] CODE_NEWLINE = 4'b1101;
  localparam logic [3:0] CODE_COMMA   = 4'b1110;
  localparam logic [3:0] CODE_END     = 4'b1111;
  localparam logic [3:0] CODE_LAST_DIGIT = 4'd9;

  // characters
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_PERIOD  = 8'h2E;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_TAB     = 8'h09;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_COMMA   = 8'h2C;
  localparam logic [7:0] CHR_DQUOTE  = 8'h22;
  localparam logic [7:0] CHR_SQUOTE  = 8'h27;
  localparam logic [7:0] CHR_NONE    = 8'h00;

  // delimiter candidates in priority order
  localparam logic [7:0] CAND_CHARS [NUM_CANDS] = '{8'h2C, 8'h3B, 8'h09, 8'h7C, 8'h5E, 8'h7E};

  // register map
  localparam logic REG_TABLE_MODE = 1'b0;

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       ended;
    logic       last;
  } ntd_result_t;

  function automatic logic [7:0] sym_char(logic [3:0] code, logic tbl, logic [7:0] delim);
    logic [7:0] chr;
    chr = CHR_NONE;
    if (code <= CODE_LAST_DIGIT) begin
      chr = CHR_ZERO + {4'd0, code};
    end else begin
      case (code)
        CODE_PERIOD:  chr = CHR_PERIOD;
        CODE_SPACE:   chr = CHR_SPACE;
        CODE_TAB:     chr = CHR_TAB;
        CODE_NEWLINE: chr = CHR_NEWLINE;
        CODE_COMMA:   chr = tbl ? delim : CHR_COMMA;
        default:      chr = CHR_NONE;
      endcase
    end
    return chr;
  endfunction

endpackage

/* sv/nibble_text_decoder_with_delimiter.sv */
// top level: packed-nibble text decoder with header delimiter detection
//
// Input stream (s_axis_*): one byte per word. Output stream (m_axis_*): one
// character per word, tuser flags a real character (bit 0) or the end marker
// (bit 1), tlast marks the final word caused by an input byte.
// APB port: register 0 (address 0) bit 0 is table_mode; write it only while idle.
// In table mode the first line is passed through one word per byte and the
// delimiter candidates are counted; from the newline on, nibble code 14 gives
// the most frequent candidate. Without table mode every byte gives two symbols.
// Code 15 gives an end-marker word, and every later byte is taken and dropped
// until reset.
// The first output word of an accepted byte is registered and shows in the
// cycle after. A byte is decoded in one pass into a two-slot result register,
// so a body byte gives up to two output words and a header byte one; a new byte
// is taken in the cycle its last result leaves, not before. A stalled receiver
// holds the slots and back-pressures the input.
// Reset empties the slots, clears the counts and quote state and selects comma.
module nibble_text_decoder_with_delimiter #(
  parameter int unsigned CountWidth = ntd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic [1:0]  m_axis_tuser,   // [0] char_valid, [1] ended
  output logic        m_axis_tlast,   // last_of_run
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ntd_pkg::*;

  logic                  table_mode_q;
  logic                  in_header_q, in_header_d;
  logic                  quote_q, quote_d;
  logic                  stopped_q, stopped_d;
  logic [CountWidth-1:0] cnt_q [NUM_CANDS];
  logic [CountWidth-1:0] best_q, best_d;
  cand_idx_t             lead_q, lead_d;
  ntd_result_t           slot0_q, slot1_q, res0, res1;
  logic [1:0]            fill_q, fill_d, n_res;

  logic       acc, pop, hdr, hit;
  logic [7:0] byte_in, delim;
  logic [3:0] hi, lo;
  cand_idx_t  hit_idx;
  logic [CountWidth-1:0] hit_new;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TABLE_MODE) ? {31'd0, table_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_MODE) begin
      table_mode_q <= pwdata[0];
    end
  end

  // handshakes
  assign m_axis_tvalid = (fill_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (fill_q == 2'd0) || (fill_q == 2'd1 && m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign byte_in = s_axis_tdata;
  assign hi      = byte_in[7:4];
  assign lo      = byte_in[3:0];
  assign hdr     = table_mode_q && in_header_q;
  assign delim   = CAND_CHARS[lead_q];

  // candidate match; saturated counters stay put
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = 0; j < NUM_CANDS; j++) begin
      if (byte_in == CAND_CHARS[j] && !(&cnt_q[j])) begin
        hit     = 1'b1;
        hit_idx = cand_idx_t'(j);
      end
    end
    hit_new = cnt_q[hit_idx] + 1'b1;
  end

  // decode one byte into up to two results and the next control state
  always_comb begin
    res0        = '0;
    res1        = '0;
    n_res       = 2'd0;
    in_header_d = in_header_q;
    quote_d     = quote_q;
    stopped_d   = stopped_q;
    best_d      = best_q;
    lead_d      = lead_q;
    if (!stopped_q) begin
      if (hdr) begin
        res0  = '{chr: byte_in, valid: 1'b1, ended: 1'b0, last: 1'b1};
        n_res = 2'd1;
        if (byte_in == CHR_NEWLINE) begin
          in_header_d = 1'b0;
        end else if (byte_in == CHR_DQUOTE || byte_in == CHR_SQUOTE) begin
          quote_d = !quote_q;
        end else if (!quote_q && hit) begin
          // running leader: strictly greater wins, a tie goes to the earlier candidate
          if (hit_new > best_q || (hit_new == best_q && hit_idx < lead_q)) begin
            best_d = hit_new;
            lead_d = hit_idx;
          end
        end
      end else if (hi == CODE_END) begin
        res0      = '{chr: CHR_NONE, valid: 1'b0, ended: 1'b1, last: 1'b1};
        n_res     = 2'd1;
        stopped_d = 1'b1;
      end else begin
        res0  = '{chr: sym_char(hi, table_mode_q, delim), valid: 1'b1, ended: 1'b0,
                  last: 1'b0};
        n_res = 2'd2;
        if (lo == CODE_END) begin
          res1      = '{chr: CHR_NONE, valid: 1'b0, ended: 1'b1, last: 1'b1};
          stopped_d = 1'b1;
        end else begin
          res1 = '{chr: sym_char(lo, table_mode_q, delim), valid: 1'b1, ended: 1'b0,
                   last: 1'b1};
        end
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (acc) begin
      fill_d = n_res;
    end else if (pop) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 2'd0;
      in_header_q <= 1'b1;
      quote_q     <= 1'b0;
      stopped_q   <= 1'b0;
      best_q      <= '0;
      lead_q      <= '0;
      for (int j = 0; j < NUM_CANDS; j++) begin
        cnt_q[j] <= '0;
      end
    end else begin
      fill_q <= fill_d;
      if (acc) begin
        in_header_q <= in_header_d;
        quote_q     <= quote_d;
        stopped_q   <= stopped_d;
        best_q      <= best_d;
        lead_q      <= lead_d;
        if (!stopped_q && hdr && byte_in != CHR_NEWLINE && !quote_q && hit) begin
          cnt_q[hit_idx] <= hit_new;
        end
      end
    end
  end

  // result slots, slot 0 drives the output
  always_ff @(posedge clk_i) begin
    if (acc) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tdata = slot0_q.chr;
  assign m_axis_tuser = {slot0_q.ended, slot0_q.valid};
  assign m_axis_tlast = slot0_q.last;

  // checks
  a_stopped_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && stopped_q |=> fill_q == 2'd0)
    else $error("byte after end marker produced output");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !m_axis_tlast |=> m_axis_tvalid && $stable(lead_q))
    else $error("second result of a byte missing");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("end marker not last of its run");

  a_header_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !stopped_q && hdr |=> fill_q == 2'd1 && m_axis_tuser[0])
    else $error("header byte did not give one character");

  a_leader_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q == cnt_q[lead_q])
    else $error("delimiter leader out of step with its counter");

endmodule

/* sim/tb_nibble_text_decoder_with_delimiter.sv */
// testbench: nibble text decoder, header delimiter choice, stream end and back-pressure checks
`timescale 1ns / 100ps

module tb_nibble_text_decoder_with_delimiter;
  import ntd_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TIE_RUN        = 75;
  localparam logic [2:0] TABLE_MODE_ADDR = 3'(4 * int'(REG_TABLE_MODE));
  localparam logic [2:0] SPARE_ADDR      = 3'(4 * (int'(REG_TABLE_MODE) + 1));

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_char
  logic [1:0]  m_axis_tuser;   // [0] char_valid, [1] ended
  logic        m_axis_tlast;   // last_of_run
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  nibble_text_decoder_with_delimiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // decoder state as the testbench sees it
  logic                       tbl_mode    = 1'b0;
  logic                       header_open = 1'b1;
  logic                       quoted      = 1'b0;
  logic [COUNT_WIDTH_DEF-1:0] delim_tally [NUM_CANDS];
  logic [7:0]                 body_delim  = CHR_COMMA;
  logic                       stream_done = 1'b0;

  ntd_result_t expected_chars [$];
  ntd_result_t want_char;

  int    mismatches    = 0;
  int    bytes_sent    = 0;
  int    chars_checked = 0;
  int    burst_left    = 0;
  int    idle_cycles   = 0;
  logic  hold_off_req  = 1'b0;
  string header_kind   = "";
  string end_kind      = "";

  initial begin
    for (int j = 0; j < NUM_CANDS; j++) delim_tally[j] = '0;
  end

  // expected words for one accepted byte
  function automatic void decode_byte(input logic [7:0] b);
    ntd_result_t r;
    logic [3:0] code;
    logic [COUNT_WIDTH_DEF-1:0] best;
    if (stream_done) return;
    if (tbl_mode && header_open) begin
      r.chr   = b;
      r.valid = 1'b1;
      r.ended = 1'b0;
      r.last  = 1'b1;
      expected_chars.push_back(r);
      if (b == CHR_NEWLINE) begin
        // most frequent candidate, earlier one wins a tie, comma if none seen
        best = '0;
        body_delim = CHR_COMMA;
        for (int j = 0; j < NUM_CANDS; j++) begin
          if (delim_tally[j] > best) begin
            best = delim_tally[j];
            body_delim = CAND_CHARS[j];
          end
        end
        header_open = 1'b0;
      end else if (b == CHR_DQUOTE || b == CHR_SQUOTE) begin
        quoted = ~quoted;
      end else if (!quoted) begin
        for (int j = 0; j < NUM_CANDS; j++)
          if (b == CAND_CHARS[j] && delim_tally[j] != '1) delim_tally[j]++;
      end
      return;
    end
    for (int i = 0; i < 2 && !stream_done; i++) begin
      code = (i == 0) ? b[7:4] : b[3:0];
      r.last = (i == 1) || (code == CODE_END);
      if (code == CODE_END) begin
        r.chr   = CHR_NONE;
        r.valid = 1'b0;
        r.ended = 1'b1;
        stream_done = 1'b1;
      end else begin
        r.valid = 1'b1;
        r.ended = 1'b0;
        case (code)
          CODE_PERIOD:  r.chr = CHR_PERIOD;
          CODE_SPACE:   r.chr = CHR_SPACE;
          CODE_TAB:     r.chr = CHR_TAB;
          CODE_NEWLINE: r.chr = CHR_NEWLINE;
          CODE_COMMA:   r.chr = tbl_mode ? body_delim : CHR_COMMA;
          default:      r.chr = CHR_ZERO + 8'(code);
        endcase
      end
      expected_chars.push_back(r);
    end
  endfunction

  // two symbols without the end code, comma code favored
  function automatic logic [7:0] random_symbol_pair();
    logic [3:0] hi;
    logic [3:0] lo;
    hi = ($urandom_range(0, 3) == 0) ? CODE_COMMA : 4'($urandom_range(0, int'(CODE_COMMA)));
    lo = ($urandom_range(0, 3) == 0) ? CODE_COMMA : 4'($urandom_range(0, int'(CODE_COMMA)));
    return {hi, lo};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    // a byte after the end gives no word, so leave room for it to pass
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_table_mode(input logic m);
    logic [31:0] rd;
    drain_results();
    apb_xfer(1'b1, TABLE_MODE_ADDR, {31'($urandom), m}, rd);
    tbl_mode = m;
    // writes past the register map must not touch the mode
    if ($urandom_range(0, 1) == 1) apb_xfer(1'b1, SPARE_ADDR, {32{~m}}, rd);
    apb_xfer(1'b0, TABLE_MODE_ADDR, '0, rd);
    if (rd[0] !== m) begin
      $error("table_mode: expected %0d, got %0d", m, rd[0]);
      mismatches++;
    end
  endtask

  task automatic test_plain_stream();
    logic [7:0] seq [13] = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD,
                             8'hEE, 8'hE0, 8'h0E, 8'h00, 8'h99, 8'hDC};
    set_table_mode(1'b0);
    foreach (seq[k]) send_byte(seq[k]);
  endtask

  task automatic test_header_line();
    logic [7:0] b;
    logic       hit;
    int         flavor;
    set_table_mode(1'b1);
    // zero byte, a byte of end codes, candidates inside quotes, closing by the other quote
    send_byte(CHR_NONE);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(CHR_DQUOTE);
    send_byte(CAND_CHARS[1]);
    send_byte(CAND_CHARS[3]);
    send_byte(CHR_COMMA);
    send_byte(CHR_SQUOTE);
    send_byte(8'h80);
    // leave table mode mid-header; a newline byte here is plain symbols
    set_table_mode(1'b0);
    send_byte(CHR_NEWLINE);
    send_byte(8'hEE);
    send_byte(8'hDD);
    set_table_mode(1'b1);
    send_byte(8'h7F);

    flavor = $urandom_range(0, 2);
    case (flavor)
      0: begin
        header_kind = "without candidates";
        repeat (150) begin
          do begin
            b = 8'($urandom);
            hit = (b == CHR_NEWLINE);
            for (int j = 0; j < NUM_CANDS; j++) if (b == CAND_CHARS[j]) hit = 1'b1;
          end while (hit);
          send_byte(b);
        end
      end
      1: begin
        header_kind = "with mixed candidates";
        repeat (150) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: b = CAND_CHARS[$urandom_range(0, NUM_CANDS - 1)];
            4:          b = CHR_DQUOTE;
            5:          b = CHR_SQUOTE;
            default: begin
              do b = 8'($urandom); while (b == CHR_NEWLINE);
            end
          endcase
          send_byte(b);
        end
      end
      default: begin
        // equal counts on two candidates, so the earlier one must win the tie
        header_kind = "with tied counts";
        if (quoted) send_byte(CHR_DQUOTE);
        repeat (TIE_RUN) send_byte(CAND_CHARS[5]);
        repeat (TIE_RUN) send_byte(CAND_CHARS[4]);
      end
    endcase
    send_byte(CHR_NEWLINE);
  endtask

  task automatic test_body_stream();
    send_byte(8'hEE);
    send_byte(8'hE5);
    send_byte(8'h5E);
    for (int phase = 0; phase < 4; phase++) begin
      set_table_mode(phase % 2 == 0);
      repeat (125) send_byte(random_symbol_pair());
    end
  endtask

  task automatic test_output_backpressure();
    set_table_mode(1'b1);
    hold_off_req = 1'b1;
    repeat (40) send_byte(random_symbol_pair());
    drain_results();
  endtask

  task automatic test_stream_end();
    set_table_mode(1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 1) begin
      end_kind = "high";
      send_byte({CODE_END, 4'($urandom)});
    end else begin
      end_kind = "low";
      send_byte({4'($urandom_range(0, int'(CODE_COMMA))), CODE_END});
    end
    repeat (12) send_byte(8'($urandom));
    set_table_mode(~tbl_mode);
    repeat (12) send_byte(8'($urandom));
    drain_results();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: out_char 0x%02h tuser %b tlast %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want_char = expected_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want_char.chr) begin
          $error("out_char: expected 0x%02h, got 0x%02h", want_char.chr, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want_char.valid) begin
          $error("char_valid: expected %0d, got %0d", want_char.valid, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tuser[1] !== want_char.ended) begin
          $error("ended: expected %0d, got %0d", want_char.ended, m_axis_tuser[1]);
          mismatches++;
        end
        if (m_axis_tlast !== want_char.last) begin
          $error("last_of_run: expected %0d, got %0d", want_char.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // receiver ready pattern, with one long hold-off on request
  initial begin : out_ready_pattern
    int style;
    int span;
    m_axis_tready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 120);
      for (int k = 0; k < span && !hold_off_req; k++) begin
        @(negedge clk_i);
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= k[0];
          default: m_axis_tready <= (k % 4 == 0);
        endcase
      end
      if (hold_off_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        m_axis_tready <= 1'b1;
        hold_off_req = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_plain_stream();
    test_header_line();
    test_body_stream();
    test_output_backpressure();
    test_stream_end();

    $display("run: %0d bytes in, %0d words checked, header %s picked delimiter 0x%02h",
             bytes_sent, chars_checked, header_kind, body_delim);
    $display("run: plain and table phases, long output hold-off, end code in %s nibble",
             end_kind);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* nibble_text_decoder_with_delimiter.f */
sv/ntd_pkg.sv
sv/nibble_text_decoder_with_delimiter.sv
sim/tb_nibble_text_decoder_with_delimiter.sv
